### design/rmpqt_pkg.sv
// ============================================================================
// rmpqt_pkg
// Shared constants for the range multiply / point query tree.
// ============================================================================
package rmpqt_pkg;

    // Word format
    localparam int WORD_W        = 32;
    localparam int FUNC_W        = 2;

    // Default sizing
    localparam int LEAVES_DEF    = 1024;
    localparam int FRAC_BITS_DEF = 16;

    // Command codes
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MUL   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd3;

endpackage

### design/rmpqt_mem.sv
// ============================================================================
// rmpqt_mem
// Node word store: one write port and one read port, read data registered.
// ============================================================================
module rmpqt_mem #(
    parameter int DEPTH = 4 * rmpqt_pkg::LEAVES_DEF,
    parameter int WIDTH = rmpqt_pkg::WORD_W
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/rmpqt_fxmul.sv
// ============================================================================
// rmpqt_fxmul
// Unsigned fixed point multiply: registered full product, then truncate
// the fraction and saturate.
// ============================================================================
module rmpqt_fxmul #(
    parameter int FRAC_BITS = rmpqt_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic [rmpqt_pkg::WORD_W-1:0]  a,
    input  logic [rmpqt_pkg::WORD_W-1:0]  b,
    output logic [rmpqt_pkg::WORD_W-1:0]  res
);

    localparam int PW = 2 * rmpqt_pkg::WORD_W;

    logic [PW-1:0] prod_reg;
    logic [PW-1:0] shifted;

    // product stage
    always_ff @(posedge clk)
    begin
        prod_reg <= PW'(a) * PW'(b);
    end

    // truncate and saturate
    always_comb
    begin
        shifted = prod_reg >> FRAC_BITS;
        if (shifted[PW-1:rmpqt_pkg::WORD_W] != '0)
        begin
            res = '1;
        end
        else
        begin
            res = shifted[rmpqt_pkg::WORD_W-1:0];
        end
    end

endmodule

### design/range_multiply_point_query_tree.sv
// ============================================================================
// range_multiply_point_query_tree
// Heap-ordered tree of Q16.16 node words with lazy range multiply and
// point query, held in one synchronous memory.
// ============================================================================
// Usage:
//   A command word (func, position, range_high, value) is taken when start
//   is high and busy is low. busy stays high while the command walks the
//   tree; one command is in flight at a time.
//   A point query returns query_value with done high for one cycle. The
//   receiver cannot stall, so the word must be taken in that cycle.
//   cfg_we / cfg_data write leaves_in_use (0 taken as 1, above LEAVES taken
//   as LEAVES); write it only while busy is low.
// Steps:
//   partly covered node: read node, read two children, two multiplies,
//   three writes (node to one, children scaled by it); fully covered node:
//   read, multiply by the factor, write; node outside the range: pop the
//   next pending node. Range multiply over 1024 leaves: about 40 nodes.
//   Point query: a push-down at each level on the way, then a leaf read.
//   Load leaf: descend to the leaf and write it. Out-of-range query: zero.
//   Clear: one memory word per cycle over all 4*LEAVES words.
// Reset: leaves_in_use returns to LEAVES and a clearing pass over all
//   4*LEAVES words sets every node to one; busy is high until it ends.
// ============================================================================
module range_multiply_point_query_tree #(
    parameter int LEAVES    = rmpqt_pkg::LEAVES_DEF,
    parameter int FRAC_BITS = rmpqt_pkg::FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [rmpqt_pkg::FUNC_W-1:0]          func,
    input  logic [$clog2(LEAVES)-1:0]             position,
    input  logic [$clog2(LEAVES)-1:0]             range_high,
    input  logic [rmpqt_pkg::WORD_W-1:0]          value,
    input  logic                                  cfg_we,
    input  logic [$clog2(LEAVES+1)-1:0]           cfg_data,
    output logic                                  done,
    output logic [rmpqt_pkg::WORD_W-1:0]          query_value
);

    localparam int WW     = rmpqt_pkg::WORD_W;
    localparam int POS_W  = $clog2(LEAVES);
    localparam int CNT_W  = $clog2(LEAVES + 1);
    localparam int SLOTS  = 4 * LEAVES;
    localparam int ADDR_W = $clog2(SLOTS);
    localparam int IDX_W  = ADDR_W + 1;
    localparam int STK_D  = POS_W + 2;
    localparam int STK_AW = $clog2(STK_D);
    localparam int SP_W   = $clog2(STK_D + 1);

    localparam logic [WW-1:0] ONE = WW'(1) << FRAC_BITS;

    // walk modes
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_MUL   = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CLR   = 4'd1;
    localparam logic [3:0] ST_VISIT = 4'd2;
    localparam logic [3:0] ST_P0    = 4'd3;
    localparam logic [3:0] ST_P1    = 4'd4;
    localparam logic [3:0] ST_P2    = 4'd5;
    localparam logic [3:0] ST_P3    = 4'd6;
    localparam logic [3:0] ST_P4    = 4'd7;
    localparam logic [3:0] ST_C_RD  = 4'd8;
    localparam logic [3:0] ST_C_MUL = 4'd9;
    localparam logic [3:0] ST_C_WR  = 4'd10;
    localparam logic [3:0] ST_Q_RD  = 4'd11;
    localparam logic [3:0] ST_Q_OUT = 4'd12;

    logic [3:0]        state_reg, state_next;
    logic [1:0]        mode_reg, mode_next;
    logic [CNT_W-1:0]  leaves_reg, leaves_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [POS_W-1:0]  lo_reg, lo_next;
    logic [POS_W-1:0]  hi_reg, hi_next;
    logic [POS_W-1:0]  lq_reg, lq_next;
    logic [POS_W-1:0]  hq_reg, hq_next;
    logic [WW-1:0]     val_reg, val_next;
    logic [WW-1:0]     par_reg, par_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic              done_reg, done_next;
    logic [WW-1:0]     qv_reg, qv_next;

    logic [IDX_W-1:0]  stk_k  [STK_D];
    logic [POS_W-1:0]  stk_lo [STK_D];
    logic [POS_W-1:0]  stk_hi [STK_D];
    logic              stk_push;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [WW-1:0]     mem_wdata, mem_rdata;
    logic [WW-1:0]     mul_b, mul_res;

    logic [POS_W:0]    mid_sum;
    logic [POS_W-1:0]  mid;
    logic [IDX_W-1:0]  c0, c1;
    logic              out_rng, can_push, disj, cov;
    logic [SP_W-1:0]   sp_dec;
    logic [CNT_W-1:0]  cfg_clamped;

    // node geometry
    always_comb
    begin
        mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
        mid      = mid_sum[POS_W:1];
        c0       = {k_reg[IDX_W-2:0], 1'b0};
        c1       = {k_reg[IDX_W-2:0], 1'b1};
        out_rng  = k_reg >= IDX_W'(SLOTS);
        can_push = k_reg < IDX_W'(SLOTS / 2);
        disj     = (hq_reg < lo_reg) || (lq_reg > hi_reg);
        cov      = (lq_reg <= lo_reg) && (hi_reg <= hq_reg);
        sp_dec   = sp_reg - SP_W'(1);
    end

    // config clamp
    always_comb
    begin
        if (cfg_data == '0)
        begin
            cfg_clamped = CNT_W'(1);
        end
        else if (cfg_data > CNT_W'(LEAVES))
        begin
            cfg_clamped = CNT_W'(LEAVES);
        end
        else
        begin
            cfg_clamped = cfg_data;
        end
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        leaves_next = cfg_we ? cfg_clamped : leaves_reg;
        clr_next    = clr_reg;
        k_next      = k_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        lq_next     = lq_reg;
        hq_next     = hq_reg;
        val_next    = val_reg;
        par_next    = par_reg;
        sp_next     = sp_reg;
        done_next   = 1'b0;
        qv_next     = qv_reg;
        stk_push    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = k_reg[ADDR_W-1:0];
        mem_wdata   = mul_res;
        mem_raddr   = k_reg[ADDR_W-1:0];
        mul_b       = par_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    k_next   = IDX_W'(1);
                    lo_next  = '0;
                    hi_next  = POS_W'(leaves_reg - CNT_W'(1));
                    lq_next  = position;
                    hq_next  = range_high;
                    val_next = value;
                    sp_next  = '0;
                    case (func)
                        rmpqt_pkg::FUNC_CLEAR:
                        begin
                            clr_next   = '0;
                            state_next = ST_CLR;
                        end
                        rmpqt_pkg::FUNC_LOAD:
                        begin
                            mode_next = MODE_LOAD;
                            if (CNT_W'(position) < leaves_reg)
                            begin
                                state_next = ST_VISIT;
                            end
                        end
                        rmpqt_pkg::FUNC_MUL:
                        begin
                            mode_next = MODE_MUL;
                            if (position <= range_high)
                            begin
                                state_next = ST_VISIT;
                            end
                        end
                        default:
                        begin
                            mode_next = MODE_QUERY;
                            if (CNT_W'(position) < leaves_reg)
                            begin
                                state_next = ST_VISIT;
                            end
                            else
                            begin
                                qv_next   = '0;
                                done_next = 1'b1;
                            end
                        end
                    endcase
                end
            end

            // sweep every node to one
            ST_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = ONE;
                clr_next  = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_VISIT:
            begin
                if (mode_reg == MODE_MUL)
                begin
                    if (out_rng || disj)
                    begin
                        // pop next pending node
                        if (sp_reg == '0)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            k_next  = stk_k[sp_dec[STK_AW-1:0]];
                            lo_next = stk_lo[sp_dec[STK_AW-1:0]];
                            hi_next = stk_hi[sp_dec[STK_AW-1:0]];
                            sp_next = sp_dec;
                        end
                    end
                    else if (cov)
                    begin
                        state_next = ST_C_RD;
                    end
                    else if (can_push)
                    begin
                        state_next = ST_P0;
                    end
                    else
                    begin
                        stk_push = 1'b1;
                        sp_next  = sp_reg + SP_W'(1);
                        k_next   = c0;
                        hi_next  = mid;
                    end
                end
                else
                begin
                    if (out_rng)
                    begin
                        state_next = ST_IDLE;
                        if (mode_reg == MODE_QUERY)
                        begin
                            qv_next   = '0;
                            done_next = 1'b1;
                        end
                    end
                    else if (lo_reg < hi_reg)
                    begin
                        if (mode_reg == MODE_QUERY && can_push)
                        begin
                            state_next = ST_P0;
                        end
                        else if (lq_reg <= mid)
                        begin
                            k_next  = c0;
                            hi_next = mid;
                        end
                        else
                        begin
                            k_next  = c1;
                            lo_next = mid + POS_W'(1);
                        end
                    end
                    else if (mode_reg == MODE_QUERY)
                    begin
                        state_next = ST_Q_RD;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        mem_wdata  = val_reg;
                        state_next = ST_IDLE;
                    end
                end
            end

            // push-down: parent factor into both children
            ST_P0:
            begin
                state_next = ST_P1;
            end
            ST_P1:
            begin
                par_next   = mem_rdata;
                mem_raddr  = c0[ADDR_W-1:0];
                mem_we     = 1'b1;
                mem_wdata  = ONE;
                state_next = ST_P2;
            end
            ST_P2:
            begin
                mem_raddr  = c1[ADDR_W-1:0];
                state_next = ST_P3;
            end
            ST_P3:
            begin
                mem_we     = 1'b1;
                mem_waddr  = c0[ADDR_W-1:0];
                state_next = ST_P4;
            end
            ST_P4:
            begin
                mem_we     = 1'b1;
                mem_waddr  = c1[ADDR_W-1:0];
                state_next = ST_VISIT;
                if (mode_reg == MODE_MUL)
                begin
                    stk_push = 1'b1;
                    sp_next  = sp_reg + SP_W'(1);
                    k_next   = c0;
                    hi_next  = mid;
                end
                else if (lq_reg <= mid)
                begin
                    k_next  = c0;
                    hi_next = mid;
                end
                else
                begin
                    k_next  = c1;
                    lo_next = mid + POS_W'(1);
                end
            end

            // fully covered node: scale in place
            ST_C_RD:
            begin
                state_next = ST_C_MUL;
            end
            ST_C_MUL:
            begin
                mul_b      = val_reg;
                state_next = ST_C_WR;
            end
            ST_C_WR:
            begin
                mem_we = 1'b1;
                if (sp_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    k_next     = stk_k[sp_dec[STK_AW-1:0]];
                    lo_next    = stk_lo[sp_dec[STK_AW-1:0]];
                    hi_next    = stk_hi[sp_dec[STK_AW-1:0]];
                    sp_next    = sp_dec;
                    state_next = ST_VISIT;
                end
            end

            // leaf read for query
            ST_Q_RD:
            begin
                state_next = ST_Q_OUT;
            end
            ST_Q_OUT:
            begin
                qv_next    = mem_rdata;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLR;
            mode_reg   <= MODE_LOAD;
            leaves_reg <= CNT_W'(LEAVES);
            clr_reg    <= '0;
            sp_reg     <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            leaves_reg <= leaves_next;
            clr_reg    <= clr_next;
            sp_reg     <= sp_next;
            done_reg   <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        k_reg   <= k_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        lq_reg  <= lq_next;
        hq_reg  <= hq_next;
        val_reg <= val_next;
        par_reg <= par_next;
        qv_reg  <= qv_next;
    end

    // pending right siblings
    always_ff @(posedge clk)
    begin
        if (stk_push)
        begin
            stk_k[sp_reg[STK_AW-1:0]]  <= c1;
            stk_lo[sp_reg[STK_AW-1:0]] <= mid + POS_W'(1);
            stk_hi[sp_reg[STK_AW-1:0]] <= hi_reg;
        end
    end

    rmpqt_mem #(
        .DEPTH (SLOTS),
        .WIDTH (WW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    rmpqt_fxmul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk (clk),
        .a   (mem_rdata),
        .b   (mul_b),
        .res (mul_res)
    );

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign query_value = qv_reg;

`ifndef SYNTHESIS
    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STK_D))
        else $error("node stack overflow");

    a_idle_stack_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (sp_reg == '0))
        else $error("stack not empty when idle");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mem_we)
        else $error("node write while idle");

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) || !done_reg || $past(state_reg == ST_Q_OUT || state_reg == ST_VISIT
            || (state_reg == ST_IDLE && start && func == rmpqt_pkg::FUNC_QUERY)))
        else $error("done without a query");
`endif

endmodule

### tb/sv/range_multiply_point_query_tree_tb.sv
// ============================================================================
// range_multiply_point_query_tree_tb
// Self-checking bench for the range multiply / point query tree. A scoreboard
// class keeps its own copy of the node words and the leaf count and predicts
// every query word. Directed corner cases come first, then randomized phases
// over several leaf counts with random start gaps.
// ============================================================================
module range_multiply_point_query_tree_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = 4 * rmpqt_pkg::LEAVES_DEF;
    localparam int CYCLE_LIMIT = 1500000;

    // Scoreboard: tree predictor plus the queue of expected query words
    class tree_scoreboard;
        bit [31:0]   node_word[SLOTS];
        int unsigned leaf_count;
        bit [31:0]   query_words[$];
        int          errors;

        function new();
            clear_all();
            leaf_count = rmpqt_pkg::LEAVES_DEF;
            errors     = 0;
        endfunction

        function void clear_all();
            foreach (node_word[i]) node_word[i] = 32'h1 << rmpqt_pkg::FRAC_BITS_DEF;
        endfunction

        // Q16.16 product, truncated and saturated
        function bit [31:0] fx_mul(bit [31:0] a, bit [31:0] b);
            bit [63:0] p;
            p = ({32'b0, a} * {32'b0, b}) >> rmpqt_pkg::FRAC_BITS_DEF;
            return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
        endfunction

        function void push_factor(int unsigned k);
            if (2 * k + 1 >= SLOTS) return;
            node_word[2*k]   = fx_mul(node_word[2*k], node_word[k]);
            node_word[2*k+1] = fx_mul(node_word[2*k+1], node_word[k]);
            node_word[k]     = 32'h1 << rmpqt_pkg::FRAC_BITS_DEF;
        endfunction

        function void scale_span(int unsigned lq, int unsigned hq, bit [31:0] f,
                                 int unsigned k, int unsigned lo, int unsigned hi);
            int unsigned mid;
            if (k >= SLOTS || hq < lo || lq > hi) return;
            if (lq <= lo && hi <= hq) begin
                node_word[k] = fx_mul(node_word[k], f);
                return;
            end
            mid = (lo + hi) / 2;
            push_factor(k);
            scale_span(lq, hq, f, 2 * k, lo, mid);
            scale_span(lq, hq, f, 2 * k + 1, mid + 1, hi);
        endfunction

        function int unsigned leaf_node(int unsigned pos, bit pushing);
            int unsigned k, lo, hi, mid;
            k  = 1;
            lo = 0;
            hi = leaf_count - 1;
            while (lo < hi && k < SLOTS) begin
                mid = (lo + hi) / 2;
                if (pushing) push_factor(k);
                if (pos <= mid) begin
                    k  = 2 * k;
                    hi = mid;
                end
                else begin
                    k  = 2 * k + 1;
                    lo = mid + 1;
                end
            end
            return k;
        endfunction

        function void set_leaves(bit [10:0] v);
            leaf_count = (v == 0) ? 1 : (v > rmpqt_pkg::LEAVES_DEF) ? rmpqt_pkg::LEAVES_DEF : v;
        endfunction

        // Apply one accepted command word
        function void note_command(bit [1:0] fn, bit [9:0] pos, bit [9:0] high,
                                   bit [31:0] val);
            int unsigned k;
            case (fn)
                rmpqt_pkg::FUNC_CLEAR: clear_all();
                rmpqt_pkg::FUNC_LOAD:
                    if (pos < leaf_count) begin
                        k = leaf_node(pos, 1'b0);
                        if (k < SLOTS) node_word[k] = val;
                    end
                rmpqt_pkg::FUNC_MUL:
                    if (pos <= high) scale_span(pos, high, val, 1, 0, leaf_count - 1);
                default: begin
                    if (pos < leaf_count) begin
                        k = leaf_node(pos, 1'b1);
                        query_words = {query_words, (k < SLOTS ? node_word[k] : 32'h0)};
                    end
                    else query_words = {query_words, 32'h0};
                end
            endcase
        endfunction

        function void check_result(bit [31:0] actual);
            bit [31:0] want;
            if (query_words.size() == 0) begin
                $error("query_value: unexpected word, actual %h", actual);
                errors++;
                return;
            end
            want = query_words.pop_front();
            if (want !== actual) begin
                $error("query_value: expected %h, actual %h", want, actual);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  func;
    logic [9:0]  position;
    logic [9:0]  range_high;
    logic [31:0] value;
    logic        cfg_we;
    logic [10:0] cfg_data;
    logic        done;
    logic [31:0] query_value;

    tree_scoreboard sb;
    int unsigned    cycles;
    bit             quiet;

    range_multiply_point_query_tree dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .position    (position),
        .range_high  (range_high),
        .value       (value),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .done        (done),
        .query_value (query_value)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Cycle limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("range_multiply_point_query_tree test failed");
            $finish;
        end
    end

    // Result monitor: done is a one-cycle strobe
    always @(posedge clk) begin
        if (rst_n && done) sb.check_result(query_value);
    end

    // Issue one command word and hold it until taken; start stays high after
    // acceptance, the caller lowers it or drives the next word.
    task automatic send_word(bit [1:0] fn, bit [9:0] pos, bit [9:0] high,
                             bit [31:0] val);
        start      <= 1'b1;
        func       <= fn;
        position   <= pos;
        range_high <= high;
        value      <= val;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_command(fn, pos, high, val);
    endtask

    // Random gap between words
    task automatic maybe_gap();
        if (!quiet && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    // Wait for quiet block, then write the leaf count
    task automatic set_leaves(bit [10:0] v);
        start <= 1'b0;
        @(posedge clk);
        while (busy || sb.query_words.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        sb.set_leaves(v);
    endtask

    // Factor mostly near one so that products stay meaningful
    function automatic bit [31:0] rand_factor();
        case ($urandom_range(0, 9))
            0:       return 32'h0;
            1:       return $urandom();
            2:       return 32'hFFFF_FFFF;
            default: return $urandom_range(32'h0000_8000, 32'h0002_0000);
        endcase
    endfunction

    task automatic random_phase(int n);
        bit [9:0]    lo, hi;
        int unsigned sel, n_leaves;
        n_leaves = sb.leaf_count;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            lo  = ($urandom_range(0, 9) == 0) ? 10'($urandom())
                                               : 10'($urandom_range(0, n_leaves - 1));
            if (sel < 2)
                send_word(rmpqt_pkg::FUNC_CLEAR, 10'($urandom()), 10'($urandom()),
                          $urandom());
            else if (sel < 35)
                send_word(rmpqt_pkg::FUNC_LOAD, lo, 10'($urandom()),
                          ($urandom_range(0, 3) == 0) ? $urandom()
                                                      : $urandom_range(0, 32'h0010_0000));
            else if (sel < 70) begin
                if ($urandom_range(0, 9) == 0)
                    hi = 10'($urandom());
                else
                    hi = 10'((lo + $urandom_range(0, n_leaves)) > 1023 ? 1023
                             : lo + $urandom_range(0, n_leaves));
                send_word(rmpqt_pkg::FUNC_MUL, lo, hi, rand_factor());
            end
            else
                send_word(rmpqt_pkg::FUNC_QUERY, lo, 10'($urandom()), $urandom());
            maybe_gap();
        end
    endtask

    initial begin
        sb         = new();
        cycles     = 0;
        quiet      = 1'b0;
        rst_n      = 1'b0;
        start      = 1'b0;
        func       = rmpqt_pkg::FUNC_CLEAR;
        position   = '0;
        range_high = '0;
        value      = '0;
        cfg_we     = 1'b0;
        cfg_data   = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes and each command at full size
        send_word(rmpqt_pkg::FUNC_QUERY, 10'd0, 10'd0, 32'h0);
        send_word(rmpqt_pkg::FUNC_LOAD, 10'd0, 10'd0, 32'hFFFF_FFFF);
        send_word(rmpqt_pkg::FUNC_LOAD, 10'd1023, 10'h3FF, 32'h0);
        send_word(rmpqt_pkg::FUNC_LOAD, 10'd512, 10'd0, 32'h0001_8000);
        send_word(rmpqt_pkg::FUNC_MUL, 10'd0, 10'd1023, 32'h0002_0000);
        send_word(rmpqt_pkg::FUNC_MUL, 10'd600, 10'd100, 32'h0000_0000);
        send_word(rmpqt_pkg::FUNC_MUL, 10'd512, 10'd512, 32'hFFFF_FFFF);
        send_word(rmpqt_pkg::FUNC_MUL, 10'd1, 10'd1022, 32'h0000_0001);
        send_word(rmpqt_pkg::FUNC_QUERY, 10'd0, 10'd0, 32'h0);
        send_word(rmpqt_pkg::FUNC_QUERY, 10'd1023, 10'd0, 32'h0);
        send_word(rmpqt_pkg::FUNC_QUERY, 10'd512, 10'h3FF, 32'hFFFF_FFFF);
        send_word(rmpqt_pkg::FUNC_QUERY, 10'd511, 10'd0, 32'h0);
        send_word(rmpqt_pkg::FUNC_CLEAR, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF);
        send_word(rmpqt_pkg::FUNC_QUERY, 10'd512, 10'd0, 32'h0);

        // Small tree: loads, queries past the end, range past the end
        set_leaves(11'd5);
        send_word(rmpqt_pkg::FUNC_LOAD, 10'd4, 10'd0, 32'h0003_0000);
        send_word(rmpqt_pkg::FUNC_LOAD, 10'd5, 10'd0, 32'h0009_0000);
        send_word(rmpqt_pkg::FUNC_LOAD, 10'd1023, 10'd0, 32'h0009_0000);
        send_word(rmpqt_pkg::FUNC_MUL, 10'd3, 10'd1023, 32'h0000_C000);
        send_word(rmpqt_pkg::FUNC_QUERY, 10'd4, 10'd0, 32'h0);
        send_word(rmpqt_pkg::FUNC_QUERY, 10'd3, 10'd0, 32'h0);
        send_word(rmpqt_pkg::FUNC_QUERY, 10'd5, 10'd0, 32'h0);
        send_word(rmpqt_pkg::FUNC_QUERY, 10'd1023, 10'd0, 32'h0);
        maybe_gap();

        // Randomized phases across leaf counts, out-of-range writes included
        random_phase(60);
        set_leaves(11'd1024);
        random_phase(60);
        set_leaves(11'd0);
        random_phase(40);
        set_leaves(11'd2047);
        random_phase(60);
        set_leaves(11'd2);
        random_phase(50);
        set_leaves(11'd100);
        random_phase(60);
        set_leaves(11'd1023);
        random_phase(60);
        set_leaves(11'd7);
        random_phase(50);
        set_leaves(11'd1000);
        random_phase(50);
        quiet = 1'b1;
        set_leaves(11'd33);
        random_phase(60);

        // Drain
        start <= 1'b0;
        @(posedge clk);
        while (busy || sb.query_words.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        if (sb.errors == 0)
            $display("range_multiply_point_query_tree test passed");
        else
            $display("range_multiply_point_query_tree test failed");
        $finish;
    end
endmodule

### filelist.f
design/rmpqt_pkg.sv
design/rmpqt_mem.sv
design/rmpqt_fxmul.sv
design/range_multiply_point_query_tree.sv
tb/sv/range_multiply_point_query_tree_tb.sv
